// ===== rtl/core/slsc_pkg.sv =====
// Shared types, constants and field widths for the S-box linearity score checker.
`timescale 1ns / 1ps

package slsc_pkg;

  // Default S-box geometry
  localparam int IN_BITS_DEF  = 6;
  localparam int OUT_BITS_DEF = 4;

  // Fixed field widths on the stream ports
  localparam int ENTRY_INDEX_W = 6;
  localparam int ENTRY_VALUE_W = 4;
  localparam int THRESH_W      = 7;
  localparam int RES_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int S_TDATA_W     = 16;
  localparam int M_TDATA_W     = 24;

  // Bound compare width: covers count + threshold + S-box size at the widest geometry
  localparam int CMP_W = 10;

  // Item kinds carried on s_tuser
  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ABOVE    = 2'd1,
    STATUS_BELOW    = 2'd2,
    STATUS_COMPLETE = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control from sequencer to the update / min-max unit
  typedef struct packed {
    logic init_scan;  // start of a scan: hi to zero, lo to S-box size
    logic init_zero;  // clear item: hi and lo to zero
    logic acc;        // read data valid this cycle
    logic add;        // increment the counter being read
  } upd_ctl_t;

endpackage

// ===== rtl/core/sbox_linearity_score_checker.sv =====
// Top level: sequencer, entry marks, bound check and stream ports of the checker.
// Items: s_tready is high only in idle, so a new item is not taken until the last one's result
//   is loaded into the result register. Each assign item walks all TOTAL = (2^IN_BITS - 1) * OUT_BITS
//   counters (252 at defaults) once, through the one read port and the one write port of the
//   counter memory. Reset: synchronous; afterwards the memory is swept to zero with s_tready
//   low. A clear item runs the same sweep.
`timescale 1ns / 1ps

module sbox_linearity_score_checker #(
  parameter int IN_BITS  = slsc_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = slsc_pkg::OUT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration
  input  logic                           cfg_we,
  input  logic [slsc_pkg::THRESH_W-1:0]  cfg_wdata,   // threshold
  // Input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [slsc_pkg::S_TDATA_W-1:0] s_tdata,     // [5:0] entry_index, [9:6] entry_value
  input  logic [0:0]                     s_tuser,     // [0] kind
  // Result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [slsc_pkg::M_TDATA_W-1:0] m_tdata      // [1:0] status, [8:2] max_count,
                                                      // [15:9] min_count, [22:16] filled_count
);

  import slsc_pkg::*;

  localparam int SBOX_SIZE = 1 << IN_BITS;
  localparam int HALF_SIZE = 1 << (IN_BITS - 1);
  localparam int TOTAL     = (SBOX_SIZE - 1) * OUT_BITS;
  localparam int ADDR_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CNT_W     = IN_BITS + 1;
  localparam int T_W       = (OUT_BITS > 1) ? $clog2(OUT_BITS) : 1;

  // Sequencer and item registers
  state_t               state, state_next;
  logic [ADDR_W-1:0]    rd_addr;
  logic [IN_BITS-1:0]   a_cnt;
  logic [T_W-1:0]       t_cnt;
  logic [IN_BITS-1:0]   idx_q;
  logic [ENTRY_VALUE_W-1:0] val_q;
  logic                 do_add;
  logic                 clr_report;

  // Read pipeline stage
  logic                 p_valid;
  logic                 p_agree;
  logic [ADDR_W-1:0]    p_addr;

  // Table bookkeeping and configuration
  logic [SBOX_SIZE-1:0] marks;
  logic [CNT_W-1:0]     marked_total;
  logic [THRESH_W-1:0]  threshold;

  // Memory and unit connections
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [CNT_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [CNT_W-1:0]     ram_rdata;
  upd_ctl_t             ctl;
  logic [CNT_W-1:0]     new_cnt;
  logic [CNT_W-1:0]     hi;
  logic [CNT_W-1:0]     lo;

  logic                 s_accept;
  logic                 last;
  logic                 in_kind;
  logic [IN_BITS-1:0]   in_idx;
  logic [7:0]           val_ext;
  logic                 in_par;
  status_t              status;
  logic [CMP_W-1:0]     upper_bound;
  logic [CMP_W-1:0]     lower_lhs;
  logic [CMP_W-1:0]     lower_rhs;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign in_kind  = s_tuser[0];
  assign in_idx   = IN_BITS'(s_tdata[ENTRY_INDEX_W-1:0]);
  assign last     = (rd_addr == ADDR_W'(TOTAL - 1));
  assign val_ext  = 8'(val_q);
  assign in_par   = ^(idx_q & a_cnt);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory port and unit control
  always_comb begin
    state_next     = state;
    ram_we         = 1'b0;
    ram_waddr      = p_addr;
    ram_wdata      = new_cnt;
    ram_re         = 1'b0;
    ctl.init_scan  = 1'b0;
    ctl.init_zero  = 1'b0;
    ctl.acc        = p_valid;
    ctl.add        = p_agree;
    if (p_valid && p_agree) begin
      ram_we = 1'b1;
    end
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_addr;
        ram_wdata = '0;
        if (last) begin
          state_next = clr_report ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          if (in_kind == KIND_CLEAR) begin
            state_next    = ST_CLEAR;
            ctl.init_zero = 1'b1;
          end else begin
            state_next    = ST_SCAN;
            ctl.init_scan = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ram_re = 1'b1;
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Counter walk: linear address plus mask / output-bit position
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      a_cnt   <= IN_BITS'(1);
      t_cnt   <= '0;
    end else if (s_accept) begin
      rd_addr <= '0;
      a_cnt   <= IN_BITS'(1);
      t_cnt   <= '0;
    end else if (state == ST_CLEAR || state == ST_SCAN) begin
      rd_addr <= rd_addr + ADDR_W'(1);
      if (t_cnt == T_W'(OUT_BITS - 1)) begin
        t_cnt <= '0;
        a_cnt <= a_cnt + IN_BITS'(1);
      end else begin
        t_cnt <= t_cnt + T_W'(1);
      end
    end
  end

  // Read stage: agreement of input parity and output bit for the issued counter
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == ST_SCAN);
    end
    p_addr  <= rd_addr;
    p_agree <= do_add && (in_par == val_ext[3'(t_cnt)]);
  end

  // Item capture, marks and filled total
  always_ff @(posedge clk) begin
    if (rst) begin
      marks        <= '0;
      marked_total <= '0;
      clr_report   <= 1'b0;
      do_add       <= 1'b0;
    end else if (s_accept) begin
      idx_q <= in_idx;
      val_q <= s_tdata[ENTRY_INDEX_W +: ENTRY_VALUE_W];
      if (in_kind == KIND_CLEAR) begin
        marks        <= '0;
        marked_total <= '0;
        clr_report   <= 1'b1;
        do_add       <= 1'b0;
      end else if (!marks[in_idx]) begin
        marks[in_idx] <= 1'b1;
        marked_total  <= marked_total + CNT_W'(1);
        do_add        <= 1'b1;
      end else begin
        do_add <= 1'b0;
      end
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Bound check: lower test rearranged to stay unsigned
  assign upper_bound = CMP_W'(HALF_SIZE) + CMP_W'(threshold);
  assign lower_lhs   = CMP_W'(lo) + CMP_W'(threshold) + CMP_W'(SBOX_SIZE);
  assign lower_rhs   = CMP_W'(HALF_SIZE) + CMP_W'(marked_total);

  always_comb begin
    if (CMP_W'(hi) > upper_bound) begin
      status = STATUS_ABOVE;
    end else if (lower_lhs < lower_rhs) begin
      status = STATUS_BELOW;
    end else if (marked_total == CNT_W'(SBOX_SIZE)) begin
      status = STATUS_COMPLETE;
    end else begin
      status = STATUS_OK;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {1'b0, RES_W'(marked_total), RES_W'(lo), RES_W'(hi), status};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  slsc_count_ram #(
    .IN_BITS  (IN_BITS),
    .OUT_BITS (OUT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  slsc_update #(
    .IN_BITS (IN_BITS)
  ) u_update (
    .clk     (clk),
    .ctl     (ctl),
    .rdata   (ram_rdata),
    .new_cnt (new_cnt),
    .hi      (hi),
    .lo      (lo)
  );

  // Filled total tracks the marks
  a_total_matches_marks: assert property (@(posedge clk) disable iff (rst)
    32'(marked_total) == $countones(marks))
    else $error("filled total out of step with entry marks");

  // Read-modify-write never collides with the read being issued
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != rd_addr))
    else $error("counter write hits the address being read");

  // Extremes are ordered when the result is formed
  a_hi_not_below_lo: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (hi >= lo))
    else $error("max count below min count at result");

  // Updates only come from a scan
  a_update_in_scan: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(state == ST_SCAN))
    else $error("counter update outside a scan");

endmodule

// ===== rtl/core/slsc_count_ram.sv =====
// Agreement counter memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module slsc_count_ram #(
  parameter int IN_BITS  = slsc_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = slsc_pkg::OUT_BITS_DEF,
  localparam int TOTAL   = ((1 << IN_BITS) - 1) * OUT_BITS,
  localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1,
  localparam int CNT_W   = IN_BITS + 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CNT_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CNT_W-1:0]  rdata
);

  logic [CNT_W-1:0] mem [TOTAL];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/slsc_update.sv =====
// Shared counter update unit: increment of the read counter and running max / min.
`timescale 1ns / 1ps

module slsc_update #(
  parameter int IN_BITS = slsc_pkg::IN_BITS_DEF,
  localparam int CNT_W  = IN_BITS + 1
) (
  input  logic              clk,
  input  slsc_pkg::upd_ctl_t ctl,
  input  logic [CNT_W-1:0]  rdata,
  output logic [CNT_W-1:0]  new_cnt,
  output logic [CNT_W-1:0]  hi,
  output logic [CNT_W-1:0]  lo
);

  import slsc_pkg::*;

  localparam int SBOX_SIZE = 1 << IN_BITS;

  // Updated counter value, also what max / min see
  assign new_cnt = rdata + CNT_W'(ctl.add);

  // Running extremes over the scan
  always_ff @(posedge clk) begin
    if (ctl.init_zero) begin
      hi <= '0;
      lo <= '0;
    end else if (ctl.init_scan) begin
      hi <= '0;
      lo <= CNT_W'(SBOX_SIZE);
    end else if (ctl.acc) begin
      if (new_cnt > hi) begin
        hi <= new_cnt;
      end
      if (new_cnt < lo) begin
        lo <= new_cnt;
      end
    end
  end

endmodule
